FILE: sv/punctured_viterbi_decoder_core_defines.svh
// Assertion macros for the punctured Viterbi decoder core.
// Included by the top level; relies on aclk and aresetn in the including scope.
`ifndef PUNCTURED_VITERBI_DECODER_CORE_DEFINES_SVH
`define PUNCTURED_VITERBI_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define PVD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PVD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pvd_pkg.sv
// Shared types, constants and the branch metric function of the Viterbi decoder.
// No dependencies.
package pvd_pkg;

    localparam int STATE_BITS = 6;
    localparam int MAX_GEN    = 4;

    localparam logic [31:0] METRIC_INIT = 32'h7FFF_FFFF;
    localparam logic [31:0] METRIC_MAX  = 32'hFFFF_FFFF;

    localparam logic [2:0] CFG_COUNT = 3'd0;
    localparam logic [2:0] CFG_GEN_A = 3'd1;
    localparam logic [2:0] CFG_GEN_B = 3'd2;
    localparam logic [2:0] CFG_GEN_C = 3'd3;
    localparam logic [2:0] CFG_GEN_D = 3'd4;

    typedef logic [MAX_GEN-1:0][6:0] gen_set_t;

    typedef struct packed {
        logic [31:0] metric;
        logic [6:0]  surv;
    } acs_res_t;

    function automatic logic [2:0] branch_dist(
        input logic [6:0]         sreg,
        input logic [MAX_GEN-1:0] bits,
        input logic [MAX_GEN-1:0] keep,
        input logic [2:0]         count,
        input gen_set_t           gens
    );
        logic [2:0] d;
        logic [2:0] cnt;
        d   = '0;
        cnt = (count > 3'(MAX_GEN)) ? 3'(MAX_GEN) : count;
        for (int i = 0; i < MAX_GEN; i++) begin
            if (3'(i) < cnt) begin
                d = d + 3'((^(sreg & gens[i]) ^ bits[i]) & keep[i]);
            end
        end
        return d;
    endfunction

endpackage

FILE: sv/pvd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pvd_acs.sv
// Shared add-compare-select unit: one next state per call from its two predecessors.
// Depends on pvd_pkg.
module pvd_acs (
    input  logic [31:0]                old_lo,
    input  logic [31:0]                old_hi,
    input  logic [4:0]                 pair,
    input  logic                       x,
    input  logic [pvd_pkg::MAX_GEN-1:0] code_bits,
    input  logic [pvd_pkg::MAX_GEN-1:0] keep_mask,
    input  logic [2:0]                 gen_count,
    input  pvd_pkg::gen_set_t          gens,
    output pvd_pkg::acs_res_t          res
);

    logic [6:0]  reg_lo, reg_hi;
    logic [32:0] sum_lo, sum_hi;
    logic [31:0] cand_lo, cand_hi;

    assign reg_lo = {1'b0, pair, x};
    assign reg_hi = {1'b1, pair, x};

    always_comb begin
        sum_lo  = {1'b0, old_lo} +
                  33'(pvd_pkg::branch_dist(reg_lo, code_bits, keep_mask, gen_count, gens));
        sum_hi  = {1'b0, old_hi} +
                  33'(pvd_pkg::branch_dist(reg_hi, code_bits, keep_mask, gen_count, gens));
        cand_lo = sum_lo[32] ? pvd_pkg::METRIC_MAX : sum_lo[31:0];
        cand_hi = sum_hi[32] ? pvd_pkg::METRIC_MAX : sum_hi[31:0];
        res.metric = pvd_pkg::METRIC_INIT;
        res.surv   = '0;
        if (cand_lo < pvd_pkg::METRIC_INIT) begin
            res.metric = cand_lo;
            res.surv   = reg_lo;
        end
        if (cand_hi < res.metric) begin
            res.metric = cand_hi;
            res.surv   = reg_hi;
        end
    end

endmodule

FILE: sv/punctured_viterbi_decoder_core.sv
// Hard-decision K=7 Viterbi decoder core with erasure-marked punctured bits.
// Depends on pvd_pkg, pvd_ram, pvd_acs and punctured_viterbi_decoder_core_defines.svh.
//
// One step beat (s_tuser = 0) runs 32 butterflies through a single shared ACS unit,
// each stepping through ST_RD_LO, ST_RD_HI, ST_X0 and ST_X1, reading old metrics from
// one page of the metric RAM and writing the other. Once TRACEBACK_DEPTH steps are
// pending, the step is preceded by a traceback walk of TRACEBACK_DEPTH survivor reads,
// each issued in ST_TB_RD and used in ST_TB_USE, then ST_OUT posts the bit once the
// output slot is free; that beat yields one output beat. A flush beat (s_tuser = 1)
// walks back from state 0 over the n pending steps and then posts n beats, oldest
// first, tlast on the final one; with nothing pending it yields no beat. The
// lowest-metric state is tracked while metrics are written, so no search pass runs.
// s_tready is high only while idle. No clearing pass is needed after reset.
`include "punctured_viterbi_decoder_core_defines.svh"
module punctured_viterbi_decoder_core #(
    parameter int TRACEBACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] code_bits, [7:4] keep_mask
    input  logic [0:0] s_tuser,   // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] decoded_bit, [7:1] zero
    output logic       m_tlast,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_wr_data
);

    localparam int CW = $clog2(TRACEBACK_DEPTH);
    localparam int LW = $clog2(TRACEBACK_DEPTH + 1);
    localparam int SB = pvd_pkg::STATE_BITS;
    localparam logic [CW-1:0] COL_LAST = CW'(TRACEBACK_DEPTH - 1);
    localparam logic [LW-1:0] PEND_FULL = LW'(TRACEBACK_DEPTH);
    localparam logic [CW:0] DEPTH_W = (CW+1)'(TRACEBACK_DEPTH);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_TB_RD  = 9'b000000010,
        ST_TB_USE = 9'b000000100,
        ST_OUT    = 9'b000001000,
        ST_EMIT   = 9'b000010000,
        ST_RD_LO  = 9'b000100000,
        ST_RD_HI  = 9'b001000000,
        ST_X0     = 9'b010000000,
        ST_X1     = 9'b100000000
    } seq_state_t;

    seq_state_t            state_reg;
    logic                  done_reg;
    logic [2:0]            gen_count_reg;
    pvd_pkg::gen_set_t     gens_reg;
    logic [LW-1:0]         pending_reg;
    logic [CW-1:0]         col_reg;
    logic                  page_reg;
    logic                  init_reg;
    logic [SB-1:0]         best_state_reg;
    logic [31:0]           best_metric_reg;
    logic [CW-1:0]         tb_col_reg;
    logic [SB-1:0]         tb_st_reg;
    logic [LW-1:0]         tb_left_reg;
    logic [CW-1:0]         emit_idx_reg;
    logic [LW-1:0]         emit_n_reg;
    logic                  op_reg;
    logic [3:0]            bits_reg;
    logic [3:0]            keep_reg;
    logic [4:0]            pair_reg;
    logic [31:0]           lo_reg;
    logic [31:0]           hi_reg;
    pvd_pkg::acs_res_t     res_reg;
    logic [SB-1:0]         res_ns_reg;
    logic                  wr_pend_reg;
    logic [TRACEBACK_DEPTH-1:0] collect_reg;
    logic                  out_bit_reg;
    logic                  m_tvalid_reg;
    logic                  m_bit_reg;
    logic                  m_last_reg;

    logic                  slot_free;
    logic [CW-1:0]         col_next;
    logic [CW-1:0]         tb_col_prev;
    logic [6:0]            met_rd_addr;
    logic [31:0]           met_rd_data;
    logic [CW+SB-1:0]      surv_rd_addr;
    logic [6:0]            surv_rd_data;
    logic [31:0]           acs_lo;
    logic [31:0]           acs_hi;
    pvd_pkg::acs_res_t     acs_res;
    logic                  in_beat;

    assign s_tready  = (state_reg == ST_IDLE) && !done_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_bit_reg};
    assign m_tlast   = m_last_reg;

    assign col_next    = (col_reg == COL_LAST) ? '0 : col_reg + CW'(1);
    assign tb_col_prev = (tb_col_reg == '0) ? COL_LAST : tb_col_reg - CW'(1);

    assign met_rd_addr  = {page_reg, state_reg == ST_RD_HI, pair_reg};
    assign surv_rd_addr = {tb_col_reg, tb_st_reg};

    assign acs_lo = init_reg ? ((pair_reg == '0) ? 32'd0 : pvd_pkg::METRIC_INIT) : lo_reg;
    assign acs_hi = init_reg ? pvd_pkg::METRIC_INIT :
                    ((state_reg == ST_X0) ? met_rd_data : hi_reg);

    pvd_acs u_acs (
        .old_lo    (acs_lo),
        .old_hi    (acs_hi),
        .pair      (pair_reg),
        .x         (state_reg == ST_X1),
        .code_bits (bits_reg),
        .keep_mask (keep_reg),
        .gen_count (gen_count_reg),
        .gens      (gens_reg),
        .res       (acs_res)
    );

    pvd_ram #(.WIDTH(32), .DEPTH(128)) u_metric_ram (
        .aclk    (aclk),
        .wr_en   (wr_pend_reg),
        .wr_addr ({~page_reg, res_ns_reg}),
        .wr_data (res_reg.metric),
        .rd_addr (met_rd_addr),
        .rd_data (met_rd_data)
    );

    pvd_ram #(.WIDTH(7), .DEPTH(TRACEBACK_DEPTH * 64)) u_surv_ram (
        .aclk    (aclk),
        .wr_en   (wr_pend_reg),
        .wr_addr ({col_next, res_ns_reg}),
        .wr_data (res_reg.surv),
        .rd_addr (surv_rd_addr),
        .rd_data (surv_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            gen_count_reg  <= 3'd4;
            gens_reg       <= {7'd91, 7'd101, 7'd121, 7'd91};
            pending_reg    <= '0;
            col_reg        <= '0;
            page_reg       <= 1'b0;
            init_reg       <= 1'b1;
            best_state_reg <= '0;
            wr_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pvd_pkg::CFG_COUNT: gen_count_reg <= cfg_wr_data[2:0];
                    pvd_pkg::CFG_GEN_A: gens_reg[0]   <= cfg_wr_data;
                    pvd_pkg::CFG_GEN_B: gens_reg[1]   <= cfg_wr_data;
                    pvd_pkg::CFG_GEN_C: gens_reg[2]   <= cfg_wr_data;
                    pvd_pkg::CFG_GEN_D: gens_reg[3]   <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            wr_pend_reg <= (state_reg == ST_X0) || (state_reg == ST_X1);
            if (wr_pend_reg) begin
                if (res_ns_reg == '0 || res_reg.metric < best_metric_reg) begin
                    best_state_reg <= res_ns_reg;
                end
            end
            done_reg <= (state_reg == ST_X1) && (pair_reg == 5'd31);
            if (done_reg) begin
                page_reg <= ~page_reg;
                col_reg  <= col_next;
                init_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        if (s_tuser[0]) begin
                            pending_reg <= '0;
                            if (pending_reg != '0) begin
                                state_reg <= ST_TB_RD;
                            end
                        end else if (pending_reg == PEND_FULL) begin
                            state_reg <= ST_TB_RD;
                        end else begin
                            pending_reg <= pending_reg + LW'(1);
                            state_reg   <= ST_RD_LO;
                        end
                    end
                end
                ST_TB_RD: begin
                    state_reg <= ST_TB_USE;
                end
                ST_TB_USE: begin
                    if (tb_left_reg == LW'(1)) begin
                        state_reg <= op_reg ? ST_EMIT : ST_OUT;
                    end else begin
                        state_reg <= ST_TB_RD;
                    end
                end
                ST_OUT: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_RD_LO;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (LW'(emit_idx_reg) + LW'(1) == emit_n_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RD_LO: begin
                    state_reg <= ST_RD_HI;
                end
                ST_RD_HI: begin
                    state_reg <= ST_X0;
                end
                ST_X0: begin
                    state_reg <= ST_X1;
                end
                ST_X1: begin
                    if (pair_reg == 5'd31) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_RD_LO;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            if (res_ns_reg == '0 || res_reg.metric < best_metric_reg) begin
                best_metric_reg <= res_reg.metric;
            end
        end
        case (state_reg)
            ST_IDLE: begin
                op_reg     <= s_tuser[0];
                bits_reg   <= s_tdata[3:0];
                keep_reg   <= s_tdata[7:4];
                pair_reg   <= '0;
                tb_col_reg <= col_reg;
                tb_st_reg  <= s_tuser[0] ? '0 : best_state_reg;
                tb_left_reg <= s_tuser[0] ? pending_reg : PEND_FULL;
                emit_n_reg <= pending_reg;
                emit_idx_reg <= '0;
            end
            ST_TB_USE: begin
                if (op_reg) begin
                    collect_reg[CW'(tb_left_reg - LW'(1))] <= surv_rd_data[0];
                end
                out_bit_reg <= surv_rd_data[0];
                tb_st_reg   <= surv_rd_data[6:1];
                tb_col_reg  <= tb_col_prev;
                tb_left_reg <= tb_left_reg - LW'(1);
            end
            ST_OUT: begin
                if (slot_free) begin
                    m_bit_reg  <= out_bit_reg;
                    m_last_reg <= 1'b1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_bit_reg    <= collect_reg[emit_idx_reg];
                    m_last_reg   <= (LW'(emit_idx_reg) + LW'(1) == emit_n_reg);
                    emit_idx_reg <= emit_idx_reg + CW'(1);
                end
            end
            ST_RD_HI: begin
                lo_reg <= met_rd_data;
            end
            ST_X0: begin
                hi_reg     <= met_rd_data;
                res_reg    <= acs_res;
                res_ns_reg <= {pair_reg, 1'b0};
            end
            ST_X1: begin
                res_reg    <= acs_res;
                res_ns_reg <= {pair_reg, 1'b1};
                pair_reg   <= pair_reg + 5'd1;
            end
            default: ;
        endcase
    end

    `PVD_ASSERT_IMP(a_pend_range, 1'b1, pending_reg <= PEND_FULL, "pending count beyond window")
    `PVD_ASSERT_IMP(a_col_range, 1'b1, {1'b0, col_reg} < DEPTH_W, "column pointer out of range")
    `PVD_ASSERT_NXT(a_flush_clears, in_beat && s_tuser[0], pending_reg == '0, "flush left steps pending")
    `PVD_ASSERT_NXT(a_step_starts_acs, in_beat && !s_tuser[0] && pending_reg != PEND_FULL, state_reg == ST_RD_LO, "short step did not start ACS")

endmodule
